@@ rtl/blec_pkg.sv @@
`timescale 1ns / 1ps

package blec_pkg;

	// Defaults for the top-level parameters
	localparam int FADE_STEPS_DEF       = 12;
	localparam int RAMP_TICKS_DEF       = 2;
	localparam int RAMP_START_TICKS_DEF = 10;

	// Item command codes
	localparam logic CMD_TICK   = 1'b0;
	localparam logic CMD_STATUS = 1'b1;

	// Layers with an effect of their own
	localparam logic [4:0] LAYER_BASE        = 5'd0;
	localparam logic [4:0] LAYER_BLINK_ONE   = 5'd1;
	localparam logic [4:0] LAYER_RAMP        = 5'd2;
	localparam logic [4:0] LAYER_BLINK_THREE = 5'd3;

	// Effect modes
	localparam logic [2:0] MODE_IDLE        = 3'd0;
	localparam logic [2:0] MODE_FADE        = 3'd1;
	localparam logic [2:0] MODE_BLINK_ONE   = 3'd2;
	localparam logic [2:0] MODE_BLINK_THREE = 3'd3;
	localparam logic [2:0] MODE_RAMP        = 3'd4;

	// Register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_BLINK_HIGH   = 3'd0;
	localparam logic [2:0] REG_BLINK_LOW    = 3'd1;
	localparam logic [2:0] REG_BLINK_PERIOD = 3'd2;
	localparam logic [2:0] REG_RAMP_MIN     = 3'd3;
	localparam logic [2:0] REG_RAMP_MAX     = 3'd4;
	localparam logic [2:0] REG_RAMP_STEP    = 3'd5;

	// Register reset values
	localparam logic [7:0] BLINK_HIGH_RST   = 8'd100;
	localparam logic [7:0] BLINK_LOW_RST    = 8'd10;
	localparam logic [7:0] BLINK_PERIOD_RST = 8'd50;
	localparam logic [7:0] RAMP_MIN_RST     = 8'd10;
	localparam logic [7:0] RAMP_MAX_RST     = 8'd100;
	localparam logic [7:0] RAMP_STEP_RST    = 8'd5;

	localparam int PADDR_W = 5;

	// Fade step request: Q1.8 curve position and the two end levels
	typedef struct packed {
		logic       go;
		logic [8:0] t;
		logic [7:0] start;
		logic [7:0] target;
	} fade_req_t;

	typedef struct packed {
		logic       done;
		logic [7:0] level;
	} fade_rsp_t;

endpackage

@@ rtl/backlight_layer_effect_controller_core.sv @@
`timescale 1ns / 1ps

// Backlight layer effect controller. Each item is a 10 ms tick (cmd 0) or a
// status sample (cmd 1); each item gives exactly one result with the LED
// brightness and a write_strobe that marks an actual LED update. An item that
// needs no fade arithmetic passes through the execute and output states; an
// item that takes a fade step also waits in the fade state for the three
// passes through the single shared multiplier that evaluates the Q1.8
// smoothstep curve plus the final sum. The block takes one item at a time
// and can accept the next item while a result is still waiting to be taken.
// The six 8-bit registers sit on the APB port at byte addresses 0, 4, .. 20
// and should be written only while the block is idle.
module backlight_layer_effect_controller_core #(
	parameter int FADE_STEPS       = blec_pkg::FADE_STEPS_DEF,
	parameter int RAMP_TICKS       = blec_pkg::RAMP_TICKS_DEF,
	parameter int RAMP_START_TICKS = blec_pkg::RAMP_START_TICKS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// item channel
	input  logic                         item_valid,
	output logic                         item_ready,
	input  logic                         cmd,
	input  logic [4:0]                   layer,
	input  logic                         is_active,
	input  logic                         lighting_on,
	input  logic [6:0]                   underglow_level,
	// result channel
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic [7:0]                   brightness,
	output logic                         write_strobe,
	// register port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [blec_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import blec_pkg::*;

	localparam logic [7:0] STEPS_N      = 8'(FADE_STEPS);
	localparam logic [8:0] T_INC        = 9'(256 / FADE_STEPS);
	localparam logic [7:0] R_INC        = 8'(256 % FADE_STEPS);
	localparam logic [7:0] RAMP_RELOAD  = 8'(RAMP_TICKS);
	localparam logic [7:0] START_RELOAD = 8'(RAMP_START_TICKS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_FADE = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	// Registers
	logic [7:0] blink_high_q, blink_low_q, blink_period_q;
	logic [7:0] ramp_min_q, ramp_max_q, ramp_step_q;

	// Sequencer and latched item
	logic [1:0] st_q;
	logic       it_cmd_q, it_active_q, it_lit_q;
	logic [4:0] it_layer_q;
	logic [6:0] it_ug_q;

	// Effect state
	logic [2:0] mode_q;
	logic       seen_valid_q, last_active_q, blink_phase_q, ramp_rising_q;
	logic [4:0] last_layer_q;
	logic [7:0] tick_countdown_q, ramp_level_q, current_level_q;
	logic [7:0] fade_step_count_q, fade_start_q, fade_target_q;
	logic       fade_running_q;
	logic [8:0] fade_t_q;
	logic [7:0] fade_rem_q;
	logic       wr_q;

	// Result register
	logic       result_valid_q, write_strobe_q;
	logic [7:0] brightness_q;

	logic       cfg_wr;
	logic [2:0] cfg_idx;

	logic       changed, entry_fade, tick_fade, fade_at_end, expired;
	logic [7:0] entry_target, half_reload, full_reload, cnt_dec;
	logic [8:0] rem_sum, t_adv;
	logic [7:0] rem_adv;
	logic [8:0] ramp_sum;
	logic [7:0] ramp_sat, ramp_next;
	logic       ramp_rising_next;

	fade_req_t  fade_req;
	fade_rsp_t  fade_rsp;

	// Register port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[4:2];

	always_comb begin
		case (cfg_idx)
			REG_BLINK_HIGH:   prdata = {24'd0, blink_high_q};
			REG_BLINK_LOW:    prdata = {24'd0, blink_low_q};
			REG_BLINK_PERIOD: prdata = {24'd0, blink_period_q};
			REG_RAMP_MIN:     prdata = {24'd0, ramp_min_q};
			REG_RAMP_MAX:     prdata = {24'd0, ramp_max_q};
			REG_RAMP_STEP:    prdata = {24'd0, ramp_step_q};
			default:          prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_high_q   <= BLINK_HIGH_RST;
			blink_low_q    <= BLINK_LOW_RST;
			blink_period_q <= BLINK_PERIOD_RST;
			ramp_min_q     <= RAMP_MIN_RST;
			ramp_max_q     <= RAMP_MAX_RST;
			ramp_step_q    <= RAMP_STEP_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_BLINK_HIGH:   blink_high_q   <= pwdata[7:0];
				REG_BLINK_LOW:    blink_low_q    <= pwdata[7:0];
				REG_BLINK_PERIOD: blink_period_q <= pwdata[7:0];
				REG_RAMP_MIN:     ramp_min_q     <= pwdata[7:0];
				REG_RAMP_MAX:     ramp_max_q     <= pwdata[7:0];
				REG_RAMP_STEP:    ramp_step_q    <= pwdata[7:0];
				default:          ;
			endcase
		end
	end

	// Decode of the latched item
	always_comb begin
		changed = !seen_valid_q || (it_layer_q != last_layer_q) ||
			(it_active_q != last_active_q);
		entry_fade = (it_cmd_q == CMD_STATUS) && changed &&
			!(it_layer_q inside {LAYER_BLINK_ONE, LAYER_RAMP, LAYER_BLINK_THREE});
		entry_target = (it_layer_q == LAYER_BASE && it_lit_q && it_active_q) ?
			{1'b0, it_ug_q} : 8'd0;
		fade_at_end = (fade_step_count_q >= STEPS_N);
		tick_fade = (it_cmd_q == CMD_TICK) && (mode_q == MODE_FADE) &&
			fade_running_q && !fade_at_end;

		// countdown reloads; zero acts as one
		half_reload = (blink_period_q[7:1] == 7'd0) ? 8'd1 : {1'b0, blink_period_q[7:1]};
		full_reload = (blink_period_q == 8'd0) ? 8'd1 : blink_period_q;
		cnt_dec = (tick_countdown_q != 8'd0) ? tick_countdown_q - 8'd1 : tick_countdown_q;
		expired = (cnt_dec == 8'd0);

		// next curve position: t = k * 256 / steps, kept as quotient and remainder
		rem_sum = {1'b0, fade_rem_q} + {1'b0, R_INC};
		if (rem_sum >= {1'b0, STEPS_N}) begin
			rem_adv = 8'(rem_sum - {1'b0, STEPS_N});
			t_adv   = fade_t_q + T_INC + 9'd1;
		end else begin
			rem_adv = rem_sum[7:0];
			t_adv   = fade_t_q + T_INC;
		end

		// triangle ramp update
		ramp_sum = {1'b0, ramp_level_q} + {1'b0, ramp_step_q};
		ramp_sat = ramp_sum[8] ? 8'hFF : ramp_sum[7:0];
		ramp_next = ramp_level_q;
		ramp_rising_next = ramp_rising_q;
		if (ramp_rising_q) begin
			if (ramp_sat >= ramp_max_q) begin
				ramp_next = ramp_max_q;
				ramp_rising_next = 1'b0;
			end else begin
				ramp_next = ramp_sat;
			end
		end else if (ramp_level_q < ramp_step_q) begin
			ramp_next = ramp_min_q;
			ramp_rising_next = 1'b1;
		end else begin
			ramp_next = ramp_level_q - ramp_step_q;
		end
	end

	// Fade step request to the shared arithmetic unit
	always_comb begin
		fade_req.go     = (st_q == ST_EXEC) && (entry_fade || tick_fade);
		fade_req.t      = entry_fade ? T_INC : t_adv;
		fade_req.start  = entry_fade ? current_level_q : fade_start_q;
		fade_req.target = entry_fade ? entry_target : fade_target_q;
	end

	blec_fade_unit u_fade (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fade_req),
		.rsp    (fade_rsp)
	);

	// Item latch
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			it_cmd_q    <= cmd;
			it_layer_q  <= layer;
			it_active_q <= is_active;
			it_lit_q    <= lighting_on;
			it_ug_q     <= underglow_level;
		end
	end

	// Sequencer and effect state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q              <= ST_IDLE;
			mode_q            <= MODE_IDLE;
			seen_valid_q      <= 1'b0;
			last_layer_q      <= 5'd0;
			last_active_q     <= 1'b0;
			blink_phase_q     <= 1'b0;
			tick_countdown_q  <= 8'd0;
			ramp_level_q      <= RAMP_MIN_RST;
			ramp_rising_q     <= 1'b1;
			fade_step_count_q <= 8'd0;
			fade_running_q    <= 1'b0;
			fade_start_q      <= 8'd0;
			fade_target_q     <= 8'd0;
			fade_t_q          <= 9'd0;
			fade_rem_q        <= 8'd0;
			current_level_q   <= 8'd0;
			wr_q              <= 1'b0;
			result_valid_q    <= 1'b0;
			brightness_q      <= 8'd0;
			write_strobe_q    <= 1'b0;
		end else begin
			// a result taken outside the output state frees the register
			if (result_valid_q && result_ready && st_q != ST_OUT) result_valid_q <= 1'b0;

			case (st_q)
				ST_IDLE: begin
					if (item_valid) st_q <= ST_EXEC;
				end

				ST_EXEC: begin
					wr_q <= 1'b0;
					st_q <= ST_OUT;
					if (it_cmd_q == CMD_STATUS) begin
						if (changed) begin
							seen_valid_q   <= 1'b1;
							last_layer_q   <= it_layer_q;
							last_active_q  <= it_active_q;
							blink_phase_q  <= 1'b0;
							ramp_level_q   <= ramp_min_q;
							ramp_rising_q  <= 1'b1;
							fade_running_q <= 1'b0;
							case (it_layer_q)
								LAYER_BLINK_ONE: begin
									mode_q           <= MODE_BLINK_ONE;
									blink_phase_q    <= !it_lit_q;
									current_level_q  <= it_lit_q ? blink_low_q : blink_high_q;
									wr_q             <= 1'b1;
									tick_countdown_q <= half_reload;
								end
								LAYER_RAMP: begin
									mode_q           <= MODE_RAMP;
									tick_countdown_q <= START_RELOAD;
								end
								LAYER_BLINK_THREE: begin
									mode_q           <= MODE_BLINK_THREE;
									current_level_q  <= blink_low_q;
									wr_q             <= 1'b1;
									tick_countdown_q <= half_reload;
								end
								default: begin
									// fade from the last level; first step taken now
									mode_q            <= MODE_FADE;
									fade_target_q     <= entry_target;
									fade_start_q      <= current_level_q;
									fade_step_count_q <= 8'd1;
									fade_t_q          <= T_INC;
									fade_rem_q        <= R_INC;
									fade_running_q    <= 1'b1;
									st_q              <= ST_FADE;
								end
							endcase
						end
					end else begin
						case (mode_q)
							MODE_FADE: begin
								if (fade_running_q) begin
									if (fade_at_end) begin
										fade_running_q  <= 1'b0;
										current_level_q <= fade_target_q;
										wr_q            <= 1'b1;
									end else begin
										fade_step_count_q <= fade_step_count_q + 8'd1;
										fade_t_q          <= t_adv;
										fade_rem_q        <= rem_adv;
										st_q              <= ST_FADE;
									end
								end
							end
							MODE_BLINK_ONE, MODE_BLINK_THREE: begin
								tick_countdown_q <= cnt_dec;
								if (expired) begin
									blink_phase_q    <= !blink_phase_q;
									current_level_q  <= blink_phase_q ? blink_low_q : blink_high_q;
									wr_q             <= 1'b1;
									tick_countdown_q <= (mode_q == MODE_BLINK_THREE) ?
										half_reload : full_reload;
								end
							end
							MODE_RAMP: begin
								tick_countdown_q <= cnt_dec;
								if (expired) begin
									current_level_q  <= ramp_level_q;
									wr_q             <= 1'b1;
									ramp_level_q     <= ramp_next;
									ramp_rising_q    <= ramp_rising_next;
									tick_countdown_q <= RAMP_RELOAD;
								end
							end
							default: ;
						endcase
					end
				end

				ST_FADE: begin
					if (fade_rsp.done) begin
						current_level_q <= fade_rsp.level;
						wr_q            <= 1'b1;
						st_q            <= ST_OUT;
					end
				end

				default: begin
					// hand the result over once the result register is free
					if (!result_valid_q || result_ready) begin
						result_valid_q <= 1'b1;
						brightness_q   <= current_level_q;
						write_strobe_q <= wr_q;
						st_q           <= ST_IDLE;
					end
				end
			endcase
		end
	end

	assign item_ready   = (st_q == ST_IDLE);
	assign result_valid = result_valid_q;
	assign brightness   = brightness_q;
	assign write_strobe = write_strobe_q;

	// a running fade always belongs to fade mode
	a_fade_mode: assert property (@(posedge clk) disable iff (!arst_n)
		fade_running_q |-> (mode_q == MODE_FADE))
		else $error("fade running outside fade mode");

	a_fade_count: assert property (@(posedge clk) disable iff (!arst_n)
		fade_step_count_q <= STEPS_N)
		else $error("fade step count beyond the step total");

	a_fade_done: assert property (@(posedge clk) disable iff (!arst_n)
		fade_rsp.done |-> (st_q == ST_FADE))
		else $error("fade result with no step waiting");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> ($past(st_q) == ST_OUT))
		else $error("result raised outside the output state");

endmodule

@@ rtl/blec_fade_unit.sv @@
`timescale 1ns / 1ps

module blec_fade_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  blec_pkg::fade_req_t req,
	output blec_pkg::fade_rsp_t rsp
);
	import blec_pkg::*;

	// Phases: square t, shape the curve, scale by the level span, sum
	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_SQ    = 3'd1;
	localparam logic [2:0] PH_SHAPE = 3'd2;
	localparam logic [2:0] PH_SCALE = 3'd3;
	localparam logic [2:0] PH_SUM   = 3'd4;

	logic [2:0]         ph_q;
	logic [8:0]         t_q;
	logic [7:0]         start_q;
	logic [7:0]         target_q;
	logic signed [8:0]  diff_q;
	logic signed [21:0] prod_q;

	logic [8:0]         frac;
	logic signed [10:0] op_a;
	logic signed [10:0] op_b;
	logic signed [10:0] sum_v;
	logic signed [10:0] tgt_v;
	logic signed [10:0] lim_v;
	logic [7:0]         level;

	// Operand select for the shared multiplier
	always_comb begin
		frac = prod_q[16:8];
		case (ph_q)
			PH_SQ: begin
				op_a = $signed({2'b00, t_q});
				op_b = $signed({2'b00, t_q});
			end
			PH_SHAPE: begin
				op_a = $signed({2'b00, frac});
				op_b = 11'sd768 - $signed({1'b0, t_q, 1'b0});
			end
			PH_SCALE: begin
				op_a = $signed({{2{diff_q[8]}}, diff_q});
				op_b = $signed({2'b00, frac});
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// Final sum: floor of product / 256, clamp at target, then to 0..255
	always_comb begin
		sum_v = $signed({3'b000, start_q}) + $signed(prod_q[18:8]);
		tgt_v = $signed({3'b000, target_q});
		lim_v = sum_v;
		if (diff_q > 9'sd0) begin
			if (sum_v > tgt_v) lim_v = tgt_v;
		end else begin
			if (sum_v < tgt_v) lim_v = tgt_v;
		end
		if (lim_v < 11'sd0) begin
			level = 8'd0;
		end else if (lim_v > 11'sd255) begin
			level = 8'd255;
		end else begin
			level = lim_v[7:0];
		end
	end

	assign rsp.done  = (ph_q == PH_SUM);
	assign rsp.level = level;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
		end else begin
			case (ph_q)
				PH_IDLE:  if (req.go) ph_q <= PH_SQ;
				PH_SQ:    ph_q <= PH_SHAPE;
				PH_SHAPE: ph_q <= PH_SCALE;
				PH_SCALE: ph_q <= PH_SUM;
				default:  ph_q <= PH_IDLE;
			endcase
		end
	end

	// Operand capture and product register
	always_ff @(posedge clk) begin
		if (ph_q == PH_IDLE && req.go) begin
			t_q      <= req.t;
			start_q  <= req.start;
			target_q <= req.target;
			diff_q   <= $signed({1'b0, req.target}) - $signed({1'b0, req.start});
		end
		if (ph_q == PH_SQ || ph_q == PH_SHAPE || ph_q == PH_SCALE) begin
			prod_q <= op_a * op_b;
		end
	end

endmodule
